>>> design/sacl_pkg.sv
// shared types and constants for the set-associative cache with lru/lfu replacement
// no dependencies

package sacl_pkg;

    localparam int USE_W = 32;
    localparam logic [USE_W-1:0] SAT_LIMIT = 32'hFFFF_FFFE;

    localparam logic POLICY_LRU = 1'b0;
    localparam logic POLICY_LFU = 1'b1;

    typedef struct packed {
        logic hit;
        logic evict;
    } t_sel_flags;

endpackage

>>> design/set_assoc_cache_lru_lfu_unit.sv
// top level of the set-associative read cache with lru/lfu replacement
// depends on sacl_pkg, sacl_ram, sacl_way_sel
//
// usage:
//   an address transfer happens at a rising edge with start high and busy low.
//   the address is split into line offset, set index and tag; the set's row
//   (valid bits, tags, usage words of all ways) is read from one ram, the ways
//   are compared and a victim picked, and the updated row is written back.
//   each address passes the ram read step, then the compare/write-back step;
//   busy is high during the latter, so no new address is taken before the
//   last one is through. the result (hit, way used, evicted valid) shows on
//   o_done for exactly one cycle, registered in the compare/write-back step;
//   the receiver cannot hold it off. a read of the next item sees the
//   previous write, since the write-back ends before the next read is issued.
//   policy register: i_cfg_valid/o_cfg_ready/i_cfg_data, 0 = lru, 1 = lfu.
//   after reset the block clears the valid bits of all SETS rows, one row per
//   cycle, holding busy high while it does; configuration writes are taken
//   throughout. SETS and LINE_BYTES are powers of two.

module set_assoc_cache_lru_lfu_unit
    import sacl_pkg::*;
#(
    parameter int SETS         = 64,
    parameter int WAYS         = 8,
    parameter int LINE_BYTES   = 64,
    parameter int ADDRESS_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_read_address,
    output logic        o_done,
    output logic        o_hit,
    output logic [2:0]  o_way_used,
    output logic        o_evicted_valid,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    localparam int OFF_W    = $clog2(LINE_BYTES);
    localparam int SET_BITS = $clog2(SETS);
    localparam int SET_W    = (SETS > 1) ? SET_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_RAW  = ADDRESS_BITS - OFF_W - SET_BITS;
    localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int ROW_W    = WAYS * (1 + TAG_W + USE_W);
    localparam int TAG_LO   = WAYS;
    localparam int USE_LO   = WAYS + WAYS * TAG_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_CLR  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [SET_W-1:0] r_clr_cnt, n_clr_cnt;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic             r_policy;
    logic [USE_W-1:0] r_clock, n_clock;
    logic             r_done;
    logic             r_hit;
    logic [WAY_W-1:0] r_way;
    logic             r_evict;

    logic [ADDRESS_BITS+31:0] addr_wide;
    logic [ADDRESS_BITS-1:0]  addr;
    logic [ADDRESS_BITS-1:0]  block;
    logic [SET_W-1:0]         in_set;
    logic [TAG_W-1:0]         in_tag;
    logic                     accept;

    logic [ROW_W-1:0]              rd_row;
    logic [ROW_W-1:0]              wr_row;
    logic [WAYS-1:0]               rd_valid, wr_valid;
    logic [WAYS-1:0][TAG_W-1:0]    rd_tag, wr_tag;
    logic [WAYS-1:0][USE_W-1:0]    rd_use, wr_use;
    logic [USE_W-1:0]              old_use;
    logic [USE_W-1:0]              new_use;

    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;

    t_sel_flags       sel_flags;
    logic [WAY_W-1:0] sel_way;
    logic [WAY_W+2:0] way_ext;

    assign addr_wide = {{ADDRESS_BITS{1'b0}}, i_read_address};
    assign addr      = addr_wide[ADDRESS_BITS-1:0];
    assign block     = addr >> OFF_W;
    assign in_set    = SET_W'(block & ADDRESS_BITS'(SETS - 1));
    assign in_tag    = TAG_W'(block >> SET_BITS);

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS),
        .AW    (SET_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_set),
        .o_rdata (rd_row)
    );

    assign rd_valid = rd_row[WAYS-1:0];
    assign rd_tag   = rd_row[USE_LO-1:TAG_LO];
    assign rd_use   = rd_row[ROW_W-1:USE_LO];

    sacl_way_sel #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .WAY_W (WAY_W)
    ) u_sel (
        .i_valid      (rd_valid),
        .i_tag        (rd_tag),
        .i_use        (rd_use),
        .i_lookup_tag (r_tag),
        .o_flags      (sel_flags),
        .o_way        (sel_way)
    );

    // access clock after this access
    always_comb begin
        n_clock = r_clock;
        if (r_state == S_LOOK && r_clock < SAT_LIMIT) begin
            n_clock = r_clock + USE_W'(1);
        end
    end

    always_comb begin
        old_use = rd_use[sel_way];
        if (r_policy == POLICY_LFU) begin
            if (!sel_flags.hit) begin
                new_use = USE_W'(1);
            end else if (old_use < SAT_LIMIT) begin
                new_use = old_use + USE_W'(1);
            end else begin
                new_use = old_use;
            end
        end else begin
            new_use = n_clock;
        end
    end

    always_comb begin
        wr_valid = rd_valid;
        wr_tag   = rd_tag;
        wr_use   = rd_use;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == sel_way) begin
                wr_valid[w] = 1'b1;
                wr_tag[w]   = r_tag;
                wr_use[w]   = new_use;
            end
        end
        wr_row = {wr_use, wr_tag, wr_valid};
    end

    assign ram_we    = (r_state == S_LOOK) || (r_state == S_CLR);
    assign ram_waddr = (r_state == S_CLR) ? r_clr_cnt : r_set;
    assign ram_wdata = (r_state == S_CLR) ? '0 : wr_row;

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_IDLE;
            end
            S_CLR: begin
                n_clr_cnt = r_clr_cnt + SET_W'(1);
                if (r_clr_cnt == SET_W'(SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cnt <= '0;
            r_policy  <= POLICY_LRU;
            r_clock   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_clock   <= n_clock;
            r_done    <= (r_state == S_LOOK);
            if (i_cfg_valid && o_cfg_ready) begin
                r_policy <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set <= in_set;
            r_tag <= in_tag;
        end
        if (r_state == S_LOOK) begin
            r_hit   <= sel_flags.hit;
            r_evict <= sel_flags.evict;
            r_way   <= sel_way;
        end
    end

    assign way_ext         = {3'b000, r_way};
    assign o_done          = r_done;
    assign o_hit           = r_hit;
    assign o_way_used      = way_ext[2:0];
    assign o_evicted_valid = r_evict;

endmodule

>>> design/sacl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/sacl_way_sel.sv
// way selection for one set: tag compare, first free way and min-usage tree
// depends on sacl_pkg

module sacl_way_sel
    import sacl_pkg::*;
#(
    parameter int WAYS  = 8,
    parameter int TAG_W = 20,
    parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic [WAYS-1:0]             i_valid,
    input  logic [WAYS-1:0][TAG_W-1:0]  i_tag,
    input  logic [WAYS-1:0][USE_W-1:0]  i_use,
    input  logic [TAG_W-1:0]            i_lookup_tag,
    output t_sel_flags                  o_flags,
    output logic [WAY_W-1:0]            o_way
);

    localparam int P = 1 << WAY_W;

    logic [WAYS-1:0]  match;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic             any_hit;
    logic             all_valid;

    logic [USE_W-1:0] node_use [1:2*P-1];
    logic [WAY_W-1:0] node_idx [1:2*P-1];

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match[w] = i_valid[w] && (i_tag[w] == i_lookup_tag);
        end
    end

    // lowest index wins
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (!i_valid[w]) begin
                free_way = WAY_W'(w);
            end
        end
    end

    assign any_hit   = |match;
    assign all_valid = &i_valid;

    // min tree, left child kept on a tie
    genvar g;
    generate
        for (g = 0; g < P; g++) begin : g_leaf
            if (g < WAYS) begin : g_real
                assign node_use[P+g] = i_use[g];
            end else begin : g_pad
                assign node_use[P+g] = '1;
            end
            assign node_idx[P+g] = WAY_W'(g);
        end
        for (g = 1; g < P; g++) begin : g_node
            logic take_right;
            assign take_right  = node_use[2*g+1] < node_use[2*g];
            assign node_use[g] = take_right ? node_use[2*g+1] : node_use[2*g];
            assign node_idx[g] = take_right ? node_idx[2*g+1] : node_idx[2*g];
        end
    endgenerate

    assign o_flags.hit   = any_hit;
    assign o_flags.evict = !any_hit && all_valid;
    assign o_way = any_hit ? hit_way : (all_valid ? node_idx[1] : free_way);

endmodule

>>> design/sacl_chk.sv
// port-level checker for the cache top level, attached by bind
// depends on set_assoc_cache_lru_lfu_unit

module sacl_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_hit,
    input logic       o_evicted_valid
);

    // accepted address makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after address transfer");

    // result shown after each address transfer
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_done)
        else $error("result missing two cycles after transfer");

    // single-cycle result strobe
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_hit |-> !o_evicted_valid)
        else $error("eviction reported on a hit");

    // block is free again when the result shows
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("block busy while result shown");

endmodule

bind set_assoc_cache_lru_lfu_unit sacl_chk u_sacl_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid)
);

>>> test/tb.sv
// testbench for set_assoc_cache_lru_lfu_unit: predicts hit, way and eviction per address
// depends on sacl_pkg and the set_assoc_cache_lru_lfu_unit rtl
`timescale 1ns / 100ps

module tb;
    import sacl_pkg::*;

    localparam int SETS = 64;
    localparam int WAYS = 8;
    localparam int LINE_BYTES = 64;
    localparam int OFS_W = $clog2(LINE_BYTES);
    localparam int SET_W = $clog2(SETS);
    localparam int TAG_W = 32 - OFS_W - SET_W;
    localparam int WATCHDOG_CYCLES = 5000;

    typedef enum logic [1:0] {
        OP_ADDR,
        OP_CFG,
        OP_DRAIN
    } stim_op_e;

    typedef struct {
        stim_op_e    op;
        logic [31:0] addr;
        logic        pol;
        int unsigned idle;
    } stim_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] way;
        logic       evicted;
    } lookup_res_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] i_read_address = '0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        busy;
    logic        o_done;
    logic        o_hit;
    logic [2:0]  o_way_used;
    logic        o_evicted_valid;
    logic        o_cfg_ready;

    // predicted cache contents
    bit              line_valid [SETS*WAYS];
    logic [TAG_W-1:0] line_tag  [SETS*WAYS];
    logic [USE_W-1:0] line_use  [SETS*WAYS];
    logic [USE_W-1:0] access_clk = '0;
    logic             policy_reg = POLICY_LRU;

    stim_t       addr_stream [$];
    lookup_res_t exp_lookups [$];
    int          n_accepted = 0;
    int          n_results = 0;
    int          stall_cnt = 0;
    bit          failed = 0;
    int unsigned cur_idle = 0;

    set_assoc_cache_lru_lfu_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_read_address  (i_read_address),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_way_used      (o_way_used),
        .o_evicted_valid (o_evicted_valid),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic lookup_res_t cache_lookup(input logic [31:0] addr);
        int unsigned      base;
        logic [TAG_W-1:0] tag;
        int               hit_way;
        int               free_way;
        int               pick;
        logic [USE_W-1:0] best;
        lookup_res_t      r;
        base = int'(addr[OFS_W+SET_W-1:OFS_W]) * WAYS;
        tag = addr[31:OFS_W+SET_W];
        hit_way = -1;
        free_way = -1;
        r = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (hit_way < 0 && line_valid[base+w] && line_tag[base+w] == tag) hit_way = w;
        end
        if (access_clk < SAT_LIMIT) access_clk = access_clk + 1;
        if (hit_way >= 0) begin
            r.hit = 1'b1;
            r.way = 3'(hit_way);
            if (policy_reg == POLICY_LFU) begin
                if (line_use[base+hit_way] < SAT_LIMIT)
                    line_use[base+hit_way] = line_use[base+hit_way] + 1;
            end else begin
                line_use[base+hit_way] = access_clk;
            end
        end else begin
            for (int w = 0; w < WAYS; w++) begin
                if (free_way < 0 && !line_valid[base+w]) free_way = w;
            end
            if (free_way >= 0) begin
                pick = free_way;
            end else begin
                // set full: smallest usage word, lowest way on a tie
                pick = 0;
                best = line_use[base];
                for (int w = 1; w < WAYS; w++) begin
                    if (line_use[base+w] < best) begin
                        best = line_use[base+w];
                        pick = w;
                    end
                end
                r.evicted = 1'b1;
            end
            line_tag[base+pick] = tag;
            line_valid[base+pick] = 1'b1;
            line_use[base+pick] = (policy_reg == POLICY_LFU) ? 32'd1 : access_clk;
            r.way = 3'(pick);
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic        nxt_start;
        logic [31:0] nxt_addr;
        logic        nxt_cfg_valid;
        logic        nxt_cfg_data;
        stim_t       head;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_read_address <= '0;
            i_cfg_valid <= 1'b0;
            i_cfg_data <= 1'b0;
        end else begin
            nxt_start = start;
            nxt_addr = i_read_address;
            nxt_cfg_valid = i_cfg_valid;
            nxt_cfg_data = i_cfg_data;
            if (start && !busy) begin
                exp_lookups.push_back(cache_lookup(i_read_address));
                n_accepted++;
                void'(addr_stream.pop_front());
                nxt_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                policy_reg = i_cfg_data;
                void'(addr_stream.pop_front());
                nxt_cfg_valid = 1'b0;
            end
            if (!nxt_start && !nxt_cfg_valid && addr_stream.size() > 0) begin
                head = addr_stream[0];
                case (head.op)
                    OP_ADDR: begin
                        if ($urandom_range(99) >= head.idle) begin
                            nxt_start = 1'b1;
                            nxt_addr = head.addr;
                        end
                    end
                    OP_CFG: begin
                        if (n_accepted == n_results) begin
                            nxt_cfg_valid = 1'b1;
                            nxt_cfg_data = head.pol;
                        end
                    end
                    OP_DRAIN: begin
                        if (n_accepted == n_results) void'(addr_stream.pop_front());
                    end
                    default: ;
                endcase
            end
            start <= nxt_start;
            i_read_address <= nxt_addr;
            i_cfg_valid <= nxt_cfg_valid;
            i_cfg_data <= nxt_cfg_data;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        lookup_res_t want;
        if (i_rst_n && o_done) begin
            if (exp_lookups.size() == 0) begin
                $error("result with no lookup pending: hit %0d way %0d evicted %0d",
                       o_hit, o_way_used, o_evicted_valid);
                failed = 1;
            end else begin
                want = exp_lookups.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    failed = 1;
                end
                if (o_way_used !== want.way) begin
                    $error("way_used: expected %0d, got %0d", want.way, o_way_used);
                    failed = 1;
                end
                if (o_evicted_valid !== want.evicted) begin
                    $error("evicted_valid: expected %0d, got %0d", want.evicted,
                           o_evicted_valid);
                    failed = 1;
                end
            end
            n_results <= n_results + 1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_done) begin
                stall_cnt <= 0;
            end else if (stall_cnt >= WATCHDOG_CYCLES) begin
                $display("** set_assoc_cache_lru_lfu_unit: FAILED **");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    task automatic push_addr(input logic [31:0] addr);
        stim_t s;
        s.op = OP_ADDR;
        s.addr = addr;
        s.pol = 1'b0;
        s.idle = cur_idle;
        addr_stream.push_back(s);
    endtask

    task automatic push_cfg(input logic pol);
        stim_t s;
        s.op = OP_CFG;
        s.addr = '0;
        s.pol = pol;
        s.idle = 0;
        addr_stream.push_back(s);
    endtask

    task automatic push_drain();
        stim_t s;
        s.op = OP_DRAIN;
        s.addr = '0;
        s.pol = 1'b0;
        s.idle = 0;
        addr_stream.push_back(s);
    endtask

    initial begin
        logic [TAG_W-1:0] pool_tag [3][12];
        logic [SET_W-1:0] pool_set [3];
        int               r;
        int               s;
        int               t;

        cur_idle = 30;
        push_cfg(POLICY_LRU);
        // address extremes, then hits on the same lines
        push_addr(32'h0000_0000);
        push_addr(32'hFFFF_FFFF);
        push_addr(32'h0000_003F);
        push_addr(32'hFFFF_FFC0);
        // lru: fill set 0, evict oldest, refresh one, evict again
        for (int k = 1; k < 8; k++) push_addr({TAG_W'(k * 20'h11111), SET_W'(0), OFS_W'(k)});
        push_addr({TAG_W'(20'h88888), SET_W'(0), OFS_W'(0)});
        push_addr({TAG_W'(20'h11111), SET_W'(0), OFS_W'(63)});
        push_addr({TAG_W'(20'h99999), SET_W'(0), OFS_W'(0)});
        push_drain();
        // lfu: fill set 5, make two ways hot, evict the least used
        push_cfg(POLICY_LFU);
        for (int k = 0; k < 8; k++) push_addr({TAG_W'(20'hF00F0 + k), SET_W'(5), OFS_W'(0)});
        push_addr({TAG_W'(20'hF00F0), SET_W'(5), OFS_W'(1)});
        push_addr({TAG_W'(20'hF00F0), SET_W'(5), OFS_W'(2)});
        push_addr({TAG_W'(20'hF00F1), SET_W'(5), OFS_W'(3)});
        push_addr({TAG_W'(20'h0F00F), SET_W'(5), OFS_W'(0)});

        for (int ph = 0; ph < 3; ph++) begin
            cur_idle = (ph == 0) ? 30 : (ph == 1) ? 48 : 0;
            for (int blk = 0; blk < 5; blk++) begin
                push_cfg(((ph + blk) % 2 == 0) ? POLICY_LRU : POLICY_LFU);
                for (int i = 0; i < 3; i++) begin
                    pool_set[i] = SET_W'($urandom_range(SETS - 1));
                    for (int j = 0; j < 12; j++) pool_tag[i][j] = TAG_W'($urandom());
                end
                for (int k = 0; k < 110; k++) begin
                    r = $urandom_range(99);
                    if (r < 2) push_drain();
                    if (r < 15) begin
                        push_addr($urandom());
                    end else begin
                        s = $urandom_range(2);
                        t = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(11);
                        push_addr({pool_tag[s][t], pool_set[s], OFS_W'($urandom_range(63))});
                    end
                end
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (addr_stream.size() != 0 || n_accepted != n_results) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (exp_lookups.size() != 0) begin
            $error("%0d lookups never answered", exp_lookups.size());
            failed = 1;
        end
        if (!failed) begin
            $display("** set_assoc_cache_lru_lfu_unit: PASSED **");
        end else begin
            $display("** set_assoc_cache_lru_lfu_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/sacl_pkg.sv
design/sacl_ram.sv
design/sacl_way_sel.sv
design/set_assoc_cache_lru_lfu_unit.sv
design/sacl_chk.sv
test/tb.sv
